>>> rtl/vao_pkg.sv
// ----------------------------------------------------------------------------
// vao_pkg
// Shared constants for the oldest-steal voice allocator: field widths and
// result action codes.
// ----------------------------------------------------------------------------
package vao_pkg;

  // field widths of one event and one result
  localparam int KeyW    = 5;
  localparam int TickW   = 32;
  localparam int ActionW = 2;
  localparam int VoiceW  = 3;
  localparam int MaskW   = 8;

  // stream payload widths, padded to whole bytes
  localparam int InDataW  = 40;
  localparam int OutDataW = 24;

  // result action codes
  localparam logic [ActionW-1:0] ACT_PRESS_FREE  = 2'd0;
  localparam logic [ActionW-1:0] ACT_PRESS_STEAL = 2'd1;
  localparam logic [ActionW-1:0] ACT_REL_FREED   = 2'd2;
  localparam logic [ActionW-1:0] ACT_REL_NONE    = 2'd3;

  typedef logic [KeyW-1:0]  key_t;
  typedef logic [TickW-1:0] tick_t;

endpackage

>>> rtl/vao_start_store.sv
// ----------------------------------------------------------------------------
// vao_start_store
// Start-time memory of the voices and the oldest-voice sweep. One entry is
// written per cycle; a sweep reads every entry in turn and keeps the voice
// with the largest age (tick minus start, modulo 2^32), lowest index on ties.
// ----------------------------------------------------------------------------
module vao_start_store #(
  parameter int VOICES = 8
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      wr_en,
  input  logic [$clog2(VOICES)-1:0] wr_idx,
  input  vao_pkg::tick_t            now,
  input  logic                      scan_go,
  output logic                      scan_done,
  output logic [$clog2(VOICES)-1:0] oldest_idx
);
  import vao_pkg::*;

  localparam int IW = $clog2(VOICES);
  localparam int CW = $clog2(VOICES + 1);

  tick_t          start_mem [VOICES];
  tick_t          rd_data_r;
  logic           busy_r, busy_nxt;
  logic           done_r, done_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic [IW-1:0]  best_idx_r, best_idx_nxt;
  tick_t          best_age_r, best_age_nxt;
  tick_t          age;
  logic           rd_en;

  assign rd_en = busy_r && (cnt_r < CW'(VOICES));
  assign age   = now - rd_data_r;

  // sweep control and running maximum; data at step n belongs to entry n-1
  always_comb begin
    busy_nxt     = busy_r;
    done_nxt     = 1'b0;
    cnt_nxt      = cnt_r;
    best_idx_nxt = best_idx_r;
    best_age_nxt = best_age_r;
    if (scan_go) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
    end else if (busy_r) begin
      cnt_nxt = cnt_r + CW'(1);
      if (cnt_r != '0) begin
        if ((cnt_r == CW'(1)) || (age > best_age_r)) begin
          best_age_nxt = age;
          best_idx_nxt = IW'(cnt_r - CW'(1));
        end
      end
      if (cnt_r == CW'(VOICES)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    best_idx_r <= best_idx_nxt;
    best_age_r <= best_age_nxt;
  end

  // start-time memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      start_mem[wr_idx] <= now;
    end
    if (rd_en) begin
      rd_data_r <= start_mem[cnt_r[IW-1:0]];
    end
  end

  assign scan_done  = done_r;
  assign oldest_idx = best_idx_r;

endmodule

>>> rtl/voice_allocator_oldest_steal.sv
// ----------------------------------------------------------------------------
// voice_allocator_oldest_steal
// Polyphonic voice allocator with oldest-note stealing.
// ----------------------------------------------------------------------------
// Each input transfer is a key-change event (key, tick). For a key below KEYS
// the pressed bit toggles; a press takes the lowest free voice, or steals the
// oldest voice when all are busy, and a release frees every voice holding the
// key. One result transfer follows each event, and the next event is accepted
// only in IDLE. An event that finds a free voice, releases, or names a key at
// or above KEYS passes through DECIDE and OUT; a steal also waits in SCAN for
// the start-time memory sweep, which reads one voice entry per cycle. Voice
// start times live in that memory; pressed, active and key bits are flops.
// ----------------------------------------------------------------------------
module voice_allocator_oldest_steal #(
  parameter int VOICES = 8,
  parameter int KEYS   = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [vao_pkg::InDataW-1:0]   in_tdata,   // key[4:0], now[36:5]
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [vao_pkg::OutDataW-1:0]  out_tdata   // action[1:0], voice[4:2],
                                                    // stolen_key[9:5],
                                                    // active_mask[17:10]
);
  import vao_pkg::*;

  localparam int IW = $clog2(VOICES);
  localparam int KW = $clog2(KEYS);

  // controller states
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECIDE = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_OUT    = 3'd3;

  logic [2:0]           state_r, state_nxt;
  key_t                 key_r, key_nxt;
  tick_t                now_r, now_nxt;
  logic [KEYS-1:0]      pressed_r, pressed_nxt;
  logic [VOICES-1:0]    active_r, active_nxt;
  key_t                 vkey_r [VOICES];
  key_t                 vkey_nxt [VOICES];
  logic [ActionW-1:0]   res_action_r, res_action_nxt;
  logic [IW-1:0]        res_voice_r, res_voice_nxt;
  key_t                 res_stolen_r, res_stolen_nxt;
  logic                 out_tvalid_r, out_tvalid_nxt;
  logic [OutDataW-1:0]  out_tdata_r, out_tdata_nxt;

  logic                 in_range;
  logic [KW-1:0]        key_idx;
  logic                 free_found;
  logic [IW-1:0]        free_idx;
  logic [VOICES-1:0]    match;
  logic [IW-1:0]        match_idx;
  logic                 wr_en;
  logic [IW-1:0]        wr_idx;
  logic                 scan_go;
  logic                 scan_done;
  logic [IW-1:0]        oldest_idx;

  assign in_tready = (state_r == S_IDLE);
  assign in_range  = (32'(key_r) < 32'(KEYS));
  assign key_idx   = KW'(key_r);

  // lowest free voice, and voices holding the event's key
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    match_idx  = '0;
    for (int v = VOICES - 1; v >= 0; v--) begin
      match[v] = active_r[v] && (vkey_r[v] == key_r);
      if (!active_r[v]) begin
        free_found = 1'b1;
        free_idx   = IW'(v);
      end
      if (match[v]) begin
        match_idx = IW'(v);
      end
    end
  end

  vao_start_store #(
    .VOICES (VOICES)
  ) u_start_store (
    .clk        (clk),
    .rst_n      (rst_n),
    .wr_en      (wr_en),
    .wr_idx     (wr_idx),
    .now        (now_r),
    .scan_go    (scan_go),
    .scan_done  (scan_done),
    .oldest_idx (oldest_idx)
  );

  // event sequencer
  always_comb begin
    state_nxt      = state_r;
    key_nxt        = key_r;
    now_nxt        = now_r;
    pressed_nxt    = pressed_r;
    active_nxt     = active_r;
    vkey_nxt       = vkey_r;
    res_action_nxt = res_action_r;
    res_voice_nxt  = res_voice_r;
    res_stolen_nxt = res_stolen_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_tdata_nxt  = out_tdata_r;
    wr_en          = 1'b0;
    wr_idx         = free_idx;
    scan_go        = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          key_nxt   = in_tdata[KeyW-1:0];
          now_nxt   = in_tdata[KeyW +: TickW];
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        res_action_nxt = ACT_REL_NONE;
        res_voice_nxt  = '0;
        res_stolen_nxt = '0;
        state_nxt      = S_OUT;
        if (in_range) begin
          pressed_nxt[key_idx] = !pressed_r[key_idx];
          if (!pressed_r[key_idx]) begin
            if (free_found) begin
              wr_en                = 1'b1;
              active_nxt[free_idx] = 1'b1;
              vkey_nxt[free_idx]   = key_r;
              res_action_nxt       = ACT_PRESS_FREE;
              res_voice_nxt        = free_idx;
            end else begin
              scan_go   = 1'b1;
              state_nxt = S_SCAN;
            end
          end else begin
            active_nxt = active_r & ~match;
            if (|match) begin
              res_action_nxt = ACT_REL_FREED;
              res_voice_nxt  = match_idx;
            end
          end
        end
      end
      S_SCAN: begin
        wr_idx = oldest_idx;
        if (scan_done) begin
          wr_en                  = 1'b1;
          res_stolen_nxt         = vkey_r[oldest_idx];
          vkey_nxt[oldest_idx]   = key_r;
          active_nxt[oldest_idx] = 1'b1;
          res_action_nxt         = ACT_PRESS_STEAL;
          res_voice_nxt          = oldest_idx;
          state_nxt              = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = OutDataW'({MaskW'(active_r), res_stolen_r,
                                      VoiceW'(res_voice_r), res_action_r});
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      pressed_r    <= '0;
      active_r     <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      pressed_r    <= pressed_nxt;
      active_r     <= active_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    key_r        <= key_nxt;
    now_r        <= now_nxt;
    vkey_r       <= vkey_nxt;
    res_action_r <= res_action_nxt;
    res_voice_r  <= res_voice_nxt;
    res_stolen_r <= res_stolen_nxt;
    out_tdata_r  <= out_tdata_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule
